### rtl/uartrb_pkg.sv
// ----------------------------------------------------------------------------
// uartrb_pkg: shared types and constants of the uart ring buffers
// event codes, stream field layout and the per-item result record
// ----------------------------------------------------------------------------
package uartrb_pkg;

    typedef enum logic [1:0] {
        MODE_RX_BYTE    = 2'd0,
        MODE_HOST_READ  = 2'd1,
        MODE_HOST_WRITE = 2'd2,
        MODE_TX_READY   = 2'd3
    } t_mode;

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // input tdata layout
    localparam int I_FRAME_ERR = 8;
    localparam int I_OVERRUN   = 9;

    // output tdata layout, byte_out in bits 7:0
    localparam int O_BYTE_VALID    = 8;
    localparam int O_ERR_FRAME     = 9;
    localparam int O_ERR_OVERRUN   = 10;
    localparam int O_ERR_OVERFLOW  = 11;
    localparam int O_RX_EMPTY      = 12;
    localparam int O_WRITE_REFUSED = 13;
    localparam int O_TX_REQUEST_ON = 14;

    // sticky error bits
    localparam logic [2:0] STICKY_OVERFLOW = 3'b100;

    typedef struct packed {
        logic       byte_valid;
        logic       src_tx;
        logic [2:0] errs;
        logic       rx_empty;
        logic       refused;
        logic       tx_req;
    } t_result_meta;

endpackage

### rtl/uartrb_ram.sv
// ----------------------------------------------------------------------------
// uartrb_ram: generic single-write, single-read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module uartrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/uart_rx_tx_ring_buffers_core.sv
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_core: uart receive and transmit byte rings
// line bytes fill the receive ring, host reads drain it; host writes fill
// the transmit ring, transmitter-ready events drain it
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata fields (lsb up)                     tuser
//  -------  ---  ----------------------------------------  -----------
//  s        in   byte_in, frame_error_in, overrun_in       mode
//  m        out  byte_out, byte_valid, err_frame,          -
//                err_overrun, err_overflow, rx_empty,
//                write_refused, tx_request_on
//
//  one item per cycle sustained while the output is not stalled, one result per item
//  a result passes the ring ram read register, then the output register
//  reset clears pointers, sticky errors and the transmit request; ring
//  contents are undefined until written and need no clearing pass
//  a stalled output holds one result, one more waits in the ram read stage,
//  then s tready drops
//
module uart_rx_tx_ring_buffers_core
    import uartrb_pkg::*;
#(
    parameter int RX_DEPTH = 32,
    parameter int TX_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // byte_in[7:0], frame_error_in, overrun_in
    input  logic [S_TUSER_W-1:0] i_s_tuser,   // mode[1:0]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata    // byte_out[7:0], byte_valid, err_frame,
                                              // err_overrun, err_overflow, rx_empty,
                                              // write_refused, tx_request_on
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    // ring pointers and status
    logic [RX_AW-1:0] r_rx_wp, n_rx_wp;
    logic [RX_AW-1:0] r_rx_rp, n_rx_rp;
    logic [TX_AW-1:0] r_tx_wp, n_tx_wp;
    logic [TX_AW-1:0] r_tx_rp, n_tx_rp;
    logic [2:0]       r_sticky, n_sticky;
    logic             r_tx_req, n_tx_req;

    // ram read stage and output register
    logic             r_s1_vld;
    t_result_meta     r_s1, n_s1;
    logic             r_out_vld;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;

    logic             s_acc;
    logic             s1_adv;
    t_mode            mode;
    logic [7:0]       byte_in;

    // pointer successors, wrap at depth
    logic [RX_AW-1:0] rx_wp_inc, rx_rp_inc;
    logic [TX_AW-1:0] tx_wp_inc, tx_rp_inc;

    // ram controls
    logic             rx_we, rx_re, tx_we, tx_re;
    logic [7:0]       rx_rdata, tx_rdata;
    logic [7:0]       out_byte;

    assign mode    = t_mode'(i_s_tuser[1:0]);
    assign byte_in = i_s_tdata[7:0];

    // handshake: the ram read stage moves on whenever the output slot frees
    assign s1_adv     = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_s1_vld || s1_adv;
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign rx_wp_inc = (r_rx_wp == RX_LAST) ? '0 : r_rx_wp + 1'b1;
    assign rx_rp_inc = (r_rx_rp == RX_LAST) ? '0 : r_rx_rp + 1'b1;
    assign tx_wp_inc = (r_tx_wp == TX_LAST) ? '0 : r_tx_wp + 1'b1;
    assign tx_rp_inc = (r_tx_rp == TX_LAST) ? '0 : r_tx_rp + 1'b1;

    // event decode: pointer moves, sticky errors and the result record
    always_comb begin
        n_rx_wp  = r_rx_wp;
        n_rx_rp  = r_rx_rp;
        n_tx_wp  = r_tx_wp;
        n_tx_rp  = r_tx_rp;
        n_sticky = r_sticky;
        n_tx_req = r_tx_req;
        rx_we    = 1'b0;
        rx_re    = 1'b0;
        tx_we    = 1'b0;
        tx_re    = 1'b0;
        n_s1     = '0;
        if (s_acc) begin
            case (mode)
                MODE_RX_BYTE: begin
                    if (rx_wp_inc == r_rx_rp) begin
                        // ring full: byte dropped, its line flags lost
                        n_sticky = r_sticky | STICKY_OVERFLOW;
                    end else begin
                        rx_we    = 1'b1;
                        n_rx_wp  = rx_wp_inc;
                        n_sticky = r_sticky | {1'b0, i_s_tdata[I_OVERRUN],
                                               i_s_tdata[I_FRAME_ERR]};
                    end
                end
                MODE_HOST_READ: begin
                    if (r_rx_wp == r_rx_rp) begin
                        n_s1.rx_empty = 1'b1;
                    end else begin
                        rx_re           = 1'b1;
                        n_rx_rp         = rx_rp_inc;
                        n_s1.byte_valid = 1'b1;
                        n_s1.errs       = r_sticky;
                        n_sticky        = '0;
                    end
                end
                MODE_HOST_WRITE: begin
                    if (tx_wp_inc == r_tx_rp) begin
                        n_s1.refused = 1'b1;
                    end else begin
                        tx_we    = 1'b1;
                        n_tx_wp  = tx_wp_inc;
                        n_tx_req = 1'b1;
                    end
                end
                MODE_TX_READY: begin
                    if (r_tx_wp == r_tx_rp) begin
                        // nothing left to send
                        n_tx_req = 1'b0;
                    end else begin
                        tx_re           = 1'b1;
                        n_tx_rp         = tx_rp_inc;
                        n_s1.byte_valid = 1'b1;
                        n_s1.src_tx     = 1'b1;
                    end
                end
                default: begin
                    n_s1 = '0;
                end
            endcase
        end
        n_s1.tx_req = n_tx_req;
    end

    // pushes store at the advanced write pointer, pops read at the
    // advanced read pointer; read data holds while the stage is stalled
    uartrb_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_wp_inc),
        .i_wdata (byte_in),
        .i_re    (rx_re),
        .i_raddr (rx_rp_inc),
        .o_rdata (rx_rdata)
    );

    uartrb_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_wp_inc),
        .i_wdata (byte_in),
        .i_re    (tx_re),
        .i_raddr (tx_rp_inc),
        .o_rdata (tx_rdata)
    );

    // result packing, byte forced to zero when none was popped
    always_comb begin
        out_byte = r_s1.src_tx ? tx_rdata : rx_rdata;
        if (!r_s1.byte_valid) begin
            out_byte = 8'h00;
        end
        n_out_data                  = '0;
        n_out_data[7:0]             = out_byte;
        n_out_data[O_BYTE_VALID]    = r_s1.byte_valid;
        n_out_data[O_ERR_FRAME]     = r_s1.errs[0];
        n_out_data[O_ERR_OVERRUN]   = r_s1.errs[1];
        n_out_data[O_ERR_OVERFLOW]  = r_s1.errs[2];
        n_out_data[O_RX_EMPTY]      = r_s1.rx_empty;
        n_out_data[O_WRITE_REFUSED] = r_s1.refused;
        n_out_data[O_TX_REQUEST_ON] = r_s1.tx_req;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wp   <= '0;
            r_rx_rp   <= '0;
            r_tx_wp   <= '0;
            r_tx_rp   <= '0;
            r_sticky  <= '0;
            r_tx_req  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rx_wp  <= n_rx_wp;
            r_rx_rp  <= n_rx_rp;
            r_tx_wp  <= n_tx_wp;
            r_tx_rp  <= n_tx_rp;
            r_sticky <= n_sticky;
            r_tx_req <= n_tx_req;
            if (s_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

### rtl/uartrb_checker.sv
// ----------------------------------------------------------------------------
// uartrb_checker: port-level assertions for the uart ring buffers
// bound to the top level, watches both stream channels
// ----------------------------------------------------------------------------
module uartrb_checker
    import uartrb_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [S_TDATA_W-1:0] i_s_tdata,
    input logic [S_TUSER_W-1:0] i_s_tuser,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // an accepted item reaches the output when the sink is ready
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) ##1 i_m_tready |=> o_m_tvalid)
        else $error("accepted item did not reach the output");

    // input backpressure only comes from a stalled output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled with output free");

    // a full transmit ring always has its request raised
    a_refused_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[O_WRITE_REFUSED] |-> o_m_tdata[O_TX_REQUEST_ON])
        else $error("write refused with transmit request off");

    // empty read or refused write carries no byte and no errors
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[O_RX_EMPTY] || o_m_tdata[O_WRITE_REFUSED])
        |-> o_m_tdata[O_ERR_OVERFLOW:0] == '0)
        else $error("failed item carries a byte or errors");

endmodule

bind uart_rx_tx_ring_buffers_core uartrb_checker u_uartrb_checker (.*);

### bench/uart_rx_tx_ring_buffers_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_core_tb: self-checking bench for the uart byte rings
// a directed opener covers empty reads, pops and the sticky flags. Random
// bursts then lean toward filling or draining either ring so that both
// reach full. A scoreboard predicts every result in order.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_core_tb;
    import uartrb_pkg::*;

    localparam int RX_DEPTH     = 32;
    localparam int TX_DEPTH     = 32;
    localparam int RANDOM_ITEMS = 2000;
    localparam int BURST_LEN    = 48;
    localparam int HOLD_OFF_LEN = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    // burst profiles: which way the random mode mix leans
    localparam int MIX_UNIFORM = 0;
    localparam int MIX_RX_FILL = 1;
    localparam int MIX_TX_FILL = 2;
    localparam int MIX_DRAIN   = 3;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       err_frame;
        logic       err_overrun;
        logic       err_overflow;
        logic       rx_empty;
        logic       write_refused;
        logic       tx_request_on;
    } t_ring_result;

    // mirrors both rings and holds the results still to come, oldest first
    class uart_ring_scoreboard;
        logic [7:0]   rx_ring [RX_DEPTH];
        logic [7:0]   tx_ring [TX_DEPTH];
        int           rx_wr, rx_rd, tx_wr, tx_rd;
        logic [2:0]   sticky;
        logic         tx_req;
        t_ring_result pending [$];
        int           mismatches, orphans, results_seen;
        int           mode_count [4];
        int           overflows, refusals, empty_reads;

        function new();
            rx_wr = 0;
            rx_rd = 0;
            tx_wr = 0;
            tx_rd = 0;
            sticky = 3'b000;
            tx_req = 1'b0;
            mismatches = 0;
            orphans = 0;
            results_seen = 0;
            overflows = 0;
            refusals = 0;
            empty_reads = 0;
            foreach (mode_count[k]) mode_count[k] = 0;
        endfunction

        function void note_item(t_mode mode, logic [7:0] data, logic fe, logic dor);
            t_ring_result r;
            int           nxt;
            r = '0;
            mode_count[mode]++;
            case (mode)
                MODE_RX_BYTE: begin
                    nxt = (rx_wr + 1) % RX_DEPTH;
                    if (nxt == rx_rd) begin
                        // ring full: byte and its line flags are lost
                        sticky |= STICKY_OVERFLOW;
                        overflows++;
                    end else begin
                        rx_wr = nxt;
                        rx_ring[nxt] = data;
                        sticky |= {1'b0, dor, fe};
                    end
                end
                MODE_HOST_READ: begin
                    if (rx_wr == rx_rd) begin
                        r.rx_empty = 1'b1;
                        empty_reads++;
                    end else begin
                        rx_rd = (rx_rd + 1) % RX_DEPTH;
                        r.byte_out = rx_ring[rx_rd];
                        r.byte_valid = 1'b1;
                        r.err_frame = sticky[0];
                        r.err_overrun = sticky[1];
                        r.err_overflow = sticky[2];
                        sticky = 3'b000;
                    end
                end
                MODE_HOST_WRITE: begin
                    nxt = (tx_wr + 1) % TX_DEPTH;
                    if (nxt == tx_rd) begin
                        r.write_refused = 1'b1;
                        refusals++;
                    end else begin
                        tx_ring[nxt] = data;
                        tx_wr = nxt;
                        tx_req = 1'b1;
                    end
                end
                default: begin
                    // transmitter ready, handled alike whatever the request bit
                    if (tx_wr == tx_rd) begin
                        tx_req = 1'b0;
                    end else begin
                        tx_rd = (tx_rd + 1) % TX_DEPTH;
                        r.byte_out = tx_ring[tx_rd];
                        r.byte_valid = 1'b1;
                    end
                end
            endcase
            r.tx_request_on = tx_req;
            pending.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            t_ring_result got, want;
            string        diffs;
            got.byte_out      = tdata[7:0];
            got.byte_valid    = tdata[O_BYTE_VALID];
            got.err_frame     = tdata[O_ERR_FRAME];
            got.err_overrun   = tdata[O_ERR_OVERRUN];
            got.err_overflow  = tdata[O_ERR_OVERFLOW];
            got.rx_empty      = tdata[O_RX_EMPTY];
            got.write_refused = tdata[O_WRITE_REFUSED];
            got.tx_request_on = tdata[O_TX_REQUEST_ON];
            results_seen++;
            if (pending.size() == 0) begin
                orphans++;
                if (mismatches + orphans <= MAX_REPORTS)
                    $display("unexpected result %0d: tdata %04h", results_seen, tdata);
                return;
            end
            want = pending.pop_front();
            diffs = "";
            if (got.byte_out !== want.byte_out) diffs = {diffs, " byte_out"};
            if (got.byte_valid !== want.byte_valid) diffs = {diffs, " byte_valid"};
            if (got.err_frame !== want.err_frame) diffs = {diffs, " err_frame"};
            if (got.err_overrun !== want.err_overrun) diffs = {diffs, " err_overrun"};
            if (got.err_overflow !== want.err_overflow) diffs = {diffs, " err_overflow"};
            if (got.rx_empty !== want.rx_empty) diffs = {diffs, " rx_empty"};
            if (got.write_refused !== want.write_refused) diffs = {diffs, " write_refused"};
            if (got.tx_request_on !== want.tx_request_on) diffs = {diffs, " tx_request_on"};
            if (diffs != "") begin
                mismatches++;
                if (mismatches + orphans <= MAX_REPORTS) begin
                    $display("result %0d wrong in%s", results_seen, diffs);
                    $display("  expected byte %02h v%b errs f%b o%b ovf%b empty %b ref %b req %b",
                             want.byte_out, want.byte_valid, want.err_frame, want.err_overrun,
                             want.err_overflow, want.rx_empty, want.write_refused,
                             want.tx_request_on);
                    $display("  actual   byte %02h v%b errs f%b o%b ovf%b empty %b ref %b req %b",
                             got.byte_out, got.byte_valid, got.err_frame, got.err_overrun,
                             got.err_overflow, got.rx_empty, got.write_refused,
                             got.tx_request_on);
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;   // byte_in[7:0], frame_error_in, overrun_in
    logic [S_TUSER_W-1:0] i_s_tuser;   // mode[1:0]
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;   // byte_out[7:0], byte_valid, err_frame, err_overrun,
                                       // err_overflow, rx_empty, write_refused, tx_request_on

    uart_ring_scoreboard ring_sb = new();

    int s_idle_pct   = 0;   // sender idles this share of cycles
    int m_stall_pct  = 0;   // receiver stalls this share of cycles
    int hold_off_req = 0;   // set once by the stimulus, consumed by the receiver
    int cycle_count;

    uart_rx_tx_ring_buffers_core #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offer one item, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_item(input t_mode mode, input logic [7:0] data,
                             input logic fe, input logic dor);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[7:0] = data;
        word[I_FRAME_ERR] = fe;
        word[I_OVERRUN] = dor;
        while ($urandom_range(99) < s_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= mode;
        i_s_tdata <= word;
        do @(posedge i_clk); while (!o_s_tready);
        ring_sb.note_item(mode, data, fe, dor);
    endtask

    // mode choice leans with the burst profile so both rings hit full and empty
    function automatic t_mode pick_mode(int mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_RX_FILL: pick_mode = (r < 75) ? MODE_RX_BYTE : t_mode'($urandom_range(3));
            MIX_TX_FILL: pick_mode = (r < 75) ? MODE_HOST_WRITE : t_mode'($urandom_range(3));
            MIX_DRAIN: begin
                if (r < 45)
                    pick_mode = MODE_HOST_READ;
                else if (r < 90)
                    pick_mode = MODE_TX_READY;
                else
                    pick_mode = t_mode'($urandom_range(3));
            end
            default: pick_mode = t_mode'($urandom_range(3));
        endcase
    endfunction

    // result side: check on each accepted item, then choose next tready
    initial begin
        int  hold_left;
        bit  hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                ring_sb.check_result(o_m_tdata);
            if (!hold_taken && hold_off_req > 0) begin
                hold_left = hold_off_req;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                // long hold-off: the block backs up and drops s tready
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= m_stall_pct);
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, ring_sb.pending.size());
        $display("FAIL uart_rx_tx_ring_buffers_core");
        $finish;
    end

    initial begin
        int    phase, n, mix, per_phase;
        t_mode mode;
        per_phase = RANDOM_ITEMS / 3;
        mix = MIX_UNIFORM;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= MODE_RX_BYTE;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opener from reset
        send_item(MODE_HOST_READ, 8'hFF, 1'b1, 1'b1);   // read with nothing received
        send_item(MODE_TX_READY, 8'hFF, 1'b1, 1'b1);    // tx ready, no request, empty ring
        send_item(MODE_HOST_WRITE, 8'h00, 1'b0, 1'b0);
        send_item(MODE_HOST_WRITE, 8'hFF, 1'b1, 1'b1);
        send_item(MODE_HOST_WRITE, 8'hA5, 1'b0, 1'b1);
        send_item(MODE_TX_READY, 8'h00, 1'b0, 1'b0);
        send_item(MODE_TX_READY, 8'h00, 1'b0, 1'b0);
        send_item(MODE_TX_READY, 8'h00, 1'b0, 1'b0);
        send_item(MODE_TX_READY, 8'h00, 1'b0, 1'b0);    // ring empty: request drops
        send_item(MODE_RX_BYTE, 8'hFF, 1'b1, 1'b0);     // frame error only
        send_item(MODE_RX_BYTE, 8'h00, 1'b0, 1'b1);     // overrun only
        send_item(MODE_RX_BYTE, 8'h5A, 1'b1, 1'b1);
        send_item(MODE_HOST_READ, 8'h00, 1'b0, 1'b0);   // reports both flags, clears them
        send_item(MODE_HOST_READ, 8'h00, 1'b0, 1'b0);
        send_item(MODE_RX_BYTE, 8'h3C, 1'b0, 1'b0);
        send_item(MODE_HOST_READ, 8'h00, 1'b0, 1'b0);
        send_item(MODE_HOST_READ, 8'h00, 1'b0, 1'b0);
        send_item(MODE_HOST_READ, 8'h00, 1'b0, 1'b0);   // empty again

        // random bursts in three idling phases
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    s_idle_pct = 30;
                    m_stall_pct = 72;
                end
                1: begin
                    s_idle_pct = 72;
                    m_stall_pct = 30;
                end
                default: begin
                    s_idle_pct = 0;
                    m_stall_pct = 0;
                    hold_off_req = HOLD_OFF_LEN;
                end
            endcase
            for (n = 0; n < per_phase; n++) begin
                if (n % BURST_LEN == 0)
                    mix = $urandom_range(MIX_DRAIN);
                mode = pick_mode(mix);
                send_item(mode, 8'($urandom), 1'($urandom), 1'($urandom));
            end
        end
        i_s_tvalid <= 1'b0;

        while (ring_sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display({"covered %0d items: %0d line bytes, %0d host reads, ",
                  "%0d host writes, %0d tx ready"},
                 ring_sb.mode_count[MODE_RX_BYTE] + ring_sb.mode_count[MODE_HOST_READ]
                 + ring_sb.mode_count[MODE_HOST_WRITE] + ring_sb.mode_count[MODE_TX_READY],
                 ring_sb.mode_count[MODE_RX_BYTE],
                 ring_sb.mode_count[MODE_HOST_READ], ring_sb.mode_count[MODE_HOST_WRITE],
                 ring_sb.mode_count[MODE_TX_READY]);
        $display("rx overflows %0d, refused writes %0d, empty reads %0d, bad %0d, extra %0d",
                 ring_sb.overflows, ring_sb.refusals, ring_sb.empty_reads,
                 ring_sb.mismatches, ring_sb.orphans);
        if (ring_sb.mismatches == 0 && ring_sb.orphans == 0 && ring_sb.pending.size() == 0) begin
            $display("PASS uart_rx_tx_ring_buffers_core");
        end else begin
            $display("FAIL uart_rx_tx_ring_buffers_core");
        end
        $finish;
    end

endmodule
